// ===== rtl/grey_to_lcd_page_bitplanes_defines.svh =====
// Assertion macros for the grey-to-LCD page bit-plane packer.
`ifndef GREY_TO_LCD_PAGE_BITPLANES_DEFINES_SVH
`define GREY_TO_LCD_PAGE_BITPLANES_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GTLPB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gtlpb check failed");

// Next-cycle implication, disabled during reset.
`define GTLPB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gtlpb check failed");

`endif

// ===== rtl/gtlpb_pkg.sv =====
// Package: constants, types and helpers for the LCD page bit-plane packer.
`timescale 1ns / 1ps

package gtlpb_pkg;

   localparam int unsigned PANEL_COLUMNS_DEFAULT = 128;
   localparam logic [7:0]  FRAME_HEIGHT_RESET    = 8'd96;
   localparam logic [7:0]  REPORT_ID             = 8'hAD;
   localparam logic [7:0]  RIGHT_FLAG            = 8'h10;
   localparam logic [7:0]  CENTER_HEIGHT         = 8'd128;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } rsp_beat_type;

   // (128 - height) / 16, truncated toward zero, in 8-bit two's complement.
   function automatic logic [7:0] sector_offset(input logic [7:0] height);
      logic [7:0] mag;
      logic [7:0] res;
      if (height <= CENTER_HEIGHT) begin
         mag = CENTER_HEIGHT - height;
         res = {4'd0, mag[7:4]};
      end else begin
         mag = height - CENTER_HEIGHT;
         res = 8'd0 - {4'd0, mag[7:4]};
      end
      return res;
   endfunction

endpackage

// ===== rtl/grey_to_lcd_page_bitplanes.sv =====
// Top level: grey pixel stream to 2bpp LCD page bit-plane report bytes.
// A pixel is registered in stage 1; any beats it makes then load into the output queue.
// Throughput: one pixel per cycle on rows that emit nothing; on an active band's last row
// pixels wait for queue room; 2 beats each (4 at a half's start), 1 out per ready cycle.
// Column store: one RAM with registered read; read at accept, written back as stage 1 moves.
// Reset clears counters, s1 valid, queue count; frame_height 96; store, data uncleared.
`timescale 1ns / 1ps
`include "grey_to_lcd_page_bitplanes_defines.svh"

module grey_to_lcd_page_bitplanes #(
   parameter int unsigned PANEL_COLUMNS = gtlpb_pkg::PANEL_COLUMNS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,   // frame_height
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] red_level
   input  logic       req_tuser,     // [0] frame_start
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] report_byte
   output logic       rsp_tlast      // report_end
);

   import gtlpb_pkg::*;

   localparam int unsigned CW   = $clog2(PANEL_COLUMNS);
   localparam int unsigned HALF = PANEL_COLUMNS / 2;
   localparam logic [CW-1:0] COL_LAST  = CW'(PANEL_COLUMNS - 1);
   localparam logic [CW-1:0] COL_HALF  = CW'(HALF);
   localparam logic [CW-1:0] COL_HLAST = CW'(HALF - 1);

   // counters and config
   logic [7:0]    height_ff, height_in;
   logic [2:0]    row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [4:0]    band_ff, band_in;

   // stage 1
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_active_ff;
   logic [CW-1:0] s1_col_ff;
   logic [2:0]    s1_row_ff;
   logic [1:0]    s1_level_ff;
   logic [7:0]    s1_sector_ff;
   logic [15:0]   rd_ff;

   // output queue
   logic [2:0]    out_cnt_ff, out_cnt_in;
   rsp_beat_type  out_q_ff [4];

   logic [15:0]   plane_mem [PANEL_COLUMNS];

   logic          accept, rsp_take;
   logic [2:0]    row_eff;
   logic [CW-1:0] col_eff;
   logic [4:0]    band_eff;
   logic          in_active;
   logic [7:0]    sector_in;

   logic [15:0]   entry_base;
   logic [7:0]    hi_plane, lo_plane;
   logic          s1_emit, s1_hdr, s1_last, out_room, s1_go, load, mem_we;

   // stage 0: counters for the incoming pixel
   always_comb begin
      row_eff   = req_tuser ? 3'd0 : row_ff;
      col_eff   = req_tuser ? '0 : col_ff;
      band_eff  = req_tuser ? 5'd0 : band_ff;
      in_active = band_eff < height_ff[7:3];
      sector_in = ({3'd0, band_eff} + sector_offset(height_ff))
                  | ((col_eff >= COL_HALF) ? RIGHT_FLAG : 8'd0);
      if (col_eff == COL_LAST) begin
         col_in  = '0;
         row_in  = row_eff + 3'd1;
         band_in = ((row_eff == 3'd7) && in_active) ? band_eff + 5'd1 : band_eff;
      end else begin
         col_in  = col_eff + CW'(1);
         row_in  = row_eff;
         band_in = band_eff;
      end
   end

   // stage 1: merge, write back, hand bytes to the output queue
   always_comb begin
      entry_base = (s1_row_ff == 3'd0) ? 16'd0 : rd_ff;
      hi_plane   = entry_base[15:8] | ({7'd0, s1_level_ff[1]} << s1_row_ff);
      lo_plane   = entry_base[7:0]  | ({7'd0, s1_level_ff[0]} << s1_row_ff);
      s1_emit    = s1_valid_ff && s1_active_ff && (s1_row_ff == 3'd7);
      s1_hdr     = (s1_col_ff == '0) || (s1_col_ff == COL_HALF);
      s1_last    = (s1_col_ff == COL_HLAST) || (s1_col_ff == COL_LAST);
      rsp_take   = rsp_tvalid && rsp_tready;
      out_room   = (out_cnt_ff == 3'd0) || ((out_cnt_ff == 3'd1) && rsp_take);
      s1_go      = s1_valid_ff && (!s1_emit || out_room);
      load       = s1_go && s1_emit;
      mem_we     = s1_go && s1_active_ff;
      req_tready = !s1_valid_ff || s1_go;
      accept     = req_tvalid && req_tready;
   end

   always_comb begin
      height_in   = csr_wr_en ? csr_wr_data : height_ff;
      s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
      priority if (load) begin
         out_cnt_in = s1_hdr ? 3'd4 : 3'd2;
      end else if (rsp_take) begin
         out_cnt_in = out_cnt_ff - 3'd1;
      end else begin
         out_cnt_in = out_cnt_ff;
      end
   end

   assign rsp_tvalid = (out_cnt_ff != 3'd0);
   assign rsp_tdata  = out_q_ff[0].data;
   assign rsp_tlast  = out_q_ff[0].last;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff   <= FRAME_HEIGHT_RESET;
         row_ff      <= 3'd0;
         col_ff      <= '0;
         band_ff     <= 5'd0;
         s1_valid_ff <= 1'b0;
         out_cnt_ff  <= 3'd0;
      end else begin
         height_ff   <= height_in;
         s1_valid_ff <= s1_valid_in;
         out_cnt_ff  <= out_cnt_in;
         if (accept) begin
            row_ff  <= row_in;
            col_ff  <= col_in;
            band_ff <= band_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_active_ff <= in_active;
         s1_col_ff    <= col_eff;
         s1_row_ff    <= row_eff;
         s1_level_ff  <= ~req_tdata[7:6];
         s1_sector_ff <= sector_in;
         rd_ff        <= (mem_we && (s1_col_ff == col_eff)) ? {hi_plane, lo_plane}
                                                            : plane_mem[col_eff];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         plane_mem[s1_col_ff] <= {hi_plane, lo_plane};
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (s1_hdr) begin
            out_q_ff[0] <= '{data: REPORT_ID,    last: 1'b0};
            out_q_ff[1] <= '{data: s1_sector_ff, last: 1'b0};
            out_q_ff[2] <= '{data: hi_plane,     last: 1'b0};
            out_q_ff[3] <= '{data: lo_plane,     last: s1_last};
         end else begin
            out_q_ff[0] <= '{data: hi_plane,     last: 1'b0};
            out_q_ff[1] <= '{data: lo_plane,     last: s1_last};
         end
      end else if (rsp_take) begin
         out_q_ff[0] <= out_q_ff[1];
         out_q_ff[1] <= out_q_ff[2];
         out_q_ff[2] <= out_q_ff[3];
      end
   end

   `GTLPB_ASSERT_NOW(a_last_is_final, clock, reset, rsp_tvalid && rsp_tlast, out_cnt_ff == 3'd1)
   `GTLPB_ASSERT_NEXT(a_hdr_leads, clock, reset, load && s1_hdr, rsp_tdata == REPORT_ID)
   `GTLPB_ASSERT_NEXT(a_s1_holds, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_col_ff))

endmodule

// ===== sim/grey_to_lcd_page_bitplanes_test.sv =====
// Testbench for the grey-to-LCD page bit-plane packer: pixel stream in, checked report beats out.
`timescale 1ns / 1ps

module grey_to_lcd_page_bitplanes_test;
   import gtlpb_pkg::*;

   localparam int COLUMNS     = PANEL_COLUMNS_DEFAULT;
   localparam int HALF        = COLUMNS / 2;
   localparam int CYCLE_LIMIT = 1000000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [7:0] csr_wr_data = 8'd0;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'd0;   // [7:0] red_level
   logic       req_tuser   = 1'b0;   // [0] frame_start
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] report_byte
   logic       rsp_tlast;            // report_end

   // expected-side copy of the packer
   logic [15:0]  plane_pairs [COLUMNS];
   logic [7:0]   frame_rows = FRAME_HEIGHT_RESET;
   int           strip_row  = 0;
   int           strip_col  = 0;
   int           strip_band = 0;
   rsp_beat_type report_queue [$];
   rsp_beat_type wanted_beat;

   int mismatches  = 0;
   int beat_count  = 0;
   int cycle_count = 0;
   bit steady      = 1'b0;

   grey_to_lcd_page_bitplanes #(
      .PANEL_COLUMNS(COLUMNS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   task automatic pack_pixel(input logic [7:0] red, input logic restart);
      logic [7:0]  shade;
      logic [15:0] pair;
      int          bands;
      int          sector;
      if (restart) begin
         strip_row  = 0;
         strip_col  = 0;
         strip_band = 0;
      end
      bands = int'(frame_rows) / 8;
      if (strip_band < bands) begin
         shade = 8'd255 - red;
         pair  = (strip_row == 0) ? 16'h0000 : plane_pairs[strip_col];
         if (shade[7]) pair[8 + strip_row] = 1'b1;
         if (shade[6]) pair[strip_row] = 1'b1;
         plane_pairs[strip_col] = pair;
         if (strip_row == 7) begin
            if (strip_col % HALF == 0) begin
               // negative offset for tall frames wraps in the byte
               sector = strip_band + (int'(CENTER_HEIGHT) - int'(frame_rows)) / 16;
               if (strip_col >= HALF) sector = sector | int'(RIGHT_FLAG);
               report_queue.push_back(rsp_beat_type'{data: REPORT_ID, last: 1'b0});
               report_queue.push_back(rsp_beat_type'{data: sector[7:0], last: 1'b0});
            end
            report_queue.push_back(rsp_beat_type'{data: pair[15:8], last: 1'b0});
            report_queue.push_back(rsp_beat_type'{data: pair[7:0],
                                                  last: (strip_col % HALF == HALF - 1)});
         end
      end
      strip_col++;
      if (strip_col >= COLUMNS) begin
         strip_col = 0;
         strip_row = (strip_row + 1) % 8;
         if (strip_row == 0 && strip_band < bands) strip_band = (strip_band + 1) % 32;
      end
   endtask

   task automatic send_pixel(input logic [7:0] red, input logic restart);
      while (!steady && $urandom_range(99) < 19) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= red;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pack_pixel(red, restart);
   endtask

   task automatic send_random(input int count, input bit restart);
      for (int i = 0; i < count; i++) send_pixel(8'($urandom_range(255)), restart && i == 0);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (report_queue.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_frame_rows(input logic [7:0] rows);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rows;
      @(posedge clock);
      frame_rows = rows;
      csr_wr_en <= 1'b0;
   endtask

   // one full band at the reset height, every grey level in every column, no idling
   task automatic test_reset_height();
      logic [7:0] picks [12];
      picks = '{8'h00, 8'hFF, 8'h3F, 8'h40, 8'h7F, 8'h80,
                8'hBF, 8'hC0, 8'h01, 8'hFE, 8'hAA, 8'h55};
      steady = 1'b1;
      for (int i = 0; i < 8 * COLUMNS; i++)
         send_pixel(picks[(i / COLUMNS * 5 + i) % 12], i == 0);
      wait_idle();
      steady = 1'b0;
   endtask

   // heights below one band emit nothing
   task automatic test_no_bands();
      set_frame_rows(8'd0);
      send_random(2 * COLUMNS, 1'b1);
      set_frame_rows(8'd7);
      send_random(8 * COLUMNS, 1'b1);
   endtask

   // one band, then rows past it are ignored until the next frame
   task automatic test_single_band_frame();
      set_frame_rows(8'd8);
      send_random(16 * COLUMNS + 5, 1'b1);
      send_random(8 * COLUMNS, 1'b1);
   endtask

   // offsets at and past the center height, full frame at the top height
   task automatic test_sector_wrap();
      set_frame_rows(CENTER_HEIGHT);
      send_random(8 * COLUMNS + HALF, 1'b1);
      set_frame_rows(8'd144);
      send_random(8 * COLUMNS, 1'b1);
      set_frame_rows(8'd255);
      send_random(255 * COLUMNS, 1'b1);
   endtask

   task automatic test_mid_frame_height_change();
      set_frame_rows(8'd8);
      send_random(11 * COLUMNS, 1'b1);
      set_frame_rows(8'd32);
      send_random(5 * COLUMNS, 1'b0);
      send_random(8 * COLUMNS, 1'b0);
      send_random(3 * COLUMNS, 1'b0);
      set_frame_rows(8'd16);
      send_random(5 * COLUMNS, 1'b0);
   endtask

   task automatic test_frame_restart();
      set_frame_rows(8'd64);
      send_random(5 * COLUMNS + $urandom_range(COLUMNS - 1), 1'b1);
      send_random(8 * COLUMNS, 1'b1);
   endtask

   task automatic test_random_frames();
      int rows;
      int height;
      for (int phase = 0; phase < 10; phase++) begin
         height = ($urandom_range(3) == 0) ? $urandom_range(255) : 8 * $urandom_range(1, 16);
         set_frame_rows(8'(height));
         steady = (phase == 4);
         rows = (height / 8 > 1 ? 2 : 1) * 8 + $urandom_range(3);
         if ($urandom_range(3) == 0) send_random($urandom_range(1, 6 * COLUMNS), 1'b1);
         send_random(rows * COLUMNS, 1'b1);
         wait_idle();
         steady = 1'b0;
      end
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 19);
      if (!reset && rsp_tvalid && rsp_tready) begin
         beat_count++;
         if (report_queue.size() == 0) begin
            if (mismatches < 10)
               $display("beat %0d unexpected: data %02h last %0b",
                        beat_count, rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            wanted_beat = report_queue.pop_front();
            if (rsp_tdata !== wanted_beat.data || rsp_tlast !== wanted_beat.last) begin
               if (mismatches < 10)
                  $display("beat %0d: expected data %02h last %0b, got data %02h last %0b",
                           beat_count, wanted_beat.data, wanted_beat.last,
                           rsp_tdata, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_height();
      test_no_bands();
      test_single_band_frame();
      test_sector_wrap();
      test_mid_frame_height_change();
      test_frame_restart();
      test_random_frames();
      wait_idle();
      repeat (16) @(posedge clock);
      if (mismatches == 0 && report_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/gtlpb_pkg.sv
rtl/grey_to_lcd_page_bitplanes.sv
sim/grey_to_lcd_page_bitplanes_test.sv
